FILE: design/pim_pkg.sv
// Shared types and constants for the pair invariant mass pipeline.
package pim_pkg;

  localparam int unsigned MASS_W    = 25;
  localparam int unsigned SQ2_RADW  = 2 * MASS_W;
  localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};

  // Pipeline advance and item valid entering a pipeline section.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

FILE: design/pim_front.sv
// Front end: squares, dot product, norm sums and the norm product.
module pim_front #(
  parameter int unsigned W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pim_pkg::pipe_ctl_t    ctl_i,
  input  logic signed [W-1:0]   ax_i,
  input  logic signed [W-1:0]   ay_i,
  input  logic signed [W-1:0]   az_i,
  input  logic signed [W-1:0]   bx_i,
  input  logic signed [W-1:0]   by_i,
  input  logic signed [W-1:0]   bz_i,
  output logic                  vld_o,
  output logic [4*W+3:0]        nprod_o,
  output logic signed [2*W:0]   dot_o
);

  localparam int unsigned NW = 2 * W + 2;
  localparam int unsigned H  = W + 1;
  localparam int unsigned PW = 4 * W + 4;

  logic [3:0] vld_q;

  logic [2*W-1:0]        sq_q [6];
  logic signed [2*W-1:0] dp_q [3];

  logic [NW-1:0]        n1_q, n2_q;
  logic signed [2*W:0]  d2_q, d3_q, d4_q;

  logic [2*H-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [PW-1:0]  nprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[2:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      // stage 1: products
      sq_q[0] <= $unsigned((2*W)'(ax_i) * (2*W)'(ax_i));
      sq_q[1] <= $unsigned((2*W)'(ay_i) * (2*W)'(ay_i));
      sq_q[2] <= $unsigned((2*W)'(az_i) * (2*W)'(az_i));
      sq_q[3] <= $unsigned((2*W)'(bx_i) * (2*W)'(bx_i));
      sq_q[4] <= $unsigned((2*W)'(by_i) * (2*W)'(by_i));
      sq_q[5] <= $unsigned((2*W)'(bz_i) * (2*W)'(bz_i));
      dp_q[0] <= ax_i * bx_i;
      dp_q[1] <= ay_i * by_i;
      dp_q[2] <= az_i * bz_i;
      // stage 2: sums
      n1_q <= NW'(sq_q[0]) + NW'(sq_q[1]) + NW'(sq_q[2]);
      n2_q <= NW'(sq_q[3]) + NW'(sq_q[4]) + NW'(sq_q[5]);
      d2_q <= (2*W+1)'(dp_q[0]) + (2*W+1)'(dp_q[1]) + (2*W+1)'(dp_q[2]);
      // stage 3: partial products of the norm product
      pp00_q <= n1_q[H-1:0]  * n2_q[H-1:0];
      pp01_q <= n1_q[H-1:0]  * n2_q[NW-1:H];
      pp10_q <= n1_q[NW-1:H] * n2_q[H-1:0];
      pp11_q <= n1_q[NW-1:H] * n2_q[NW-1:H];
      d3_q   <= d2_q;
      // stage 4: combine
      nprod_q <= PW'(pp00_q) + ((PW'(pp01_q) + PW'(pp10_q)) << H) + (PW'(pp11_q) << (2*H));
      d4_q    <= d3_q;
    end
  end

  assign vld_o   = vld_q[3];
  assign nprod_o = nprod_q;
  assign dot_o   = d4_q;

endmodule

FILE: design/pim_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module pim_isqrt #(
  parameter int unsigned RADW = 8,
  parameter int unsigned SW   = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pim_pkg::pipe_ctl_t ctl_i,
  input  logic [RADW-1:0]    rad_i,
  input  logic [SW-1:0]      side_i,
  output logic               vld_o,
  output logic [RADW/2-1:0]  root_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NB = RADW / 2;

  logic            vld_q  [NB];
  logic [RADW-1:0] rem_q  [NB];
  logic [NB-1:0]   root_q [NB];
  logic [SW-1:0]   side_q [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [RADW-1:0] rem_in;
    logic [NB-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic            vld_in;
    logic [RADW:0]   trial;
    logic            take;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = ctl_i.vld;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = ((RADW+1)'(root_in) << (NB - i))
                 + ((RADW+1)'(1) << (2 * (NB - 1 - i)));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[i]  <= take ? rem_in - trial[RADW-1:0] : rem_in;
        root_q[i] <= take ? (root_in | (NB'(1) << (NB - 1 - i))) : root_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NB-1];
  assign root_o = root_q[NB-1];
  assign side_o = side_q[NB-1];

endmodule

FILE: design/pair_invariant_mass_unit.sv
// Invariant mass of a massless particle pair.
// Throughput one item per cycle; the front end, two root pipelines (one bit per
// stage) and the output register advance together and hold on an output stall.
// The norm-product root is 2*W+2 stages deep.
// Reset (rst_ni, async low) clears the valid bits; data registers are not reset.
module pair_invariant_mass_unit #(
  parameter int unsigned MOMENTUM_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // first_px, first_py, first_pz, second_px, second_py, second_pz, zero pad
  input  logic [((6*MOMENTUM_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // pair_mass, zero pad
  output logic [31:0]                 m_axis_tdata_o,
  // mass_valid
  output logic                        m_axis_tuser_o
);

  localparam int unsigned W   = MOMENTUM_WIDTH;
  localparam int unsigned R1W = 4 * W + 4;
  localparam int unsigned PW  = 2 * W + 2;
  localparam int unsigned QW  = 2 * W + 3;
  localparam int unsigned SRW = pim_pkg::SQ2_RADW;
  localparam int unsigned XW  = (QW > SRW) ? QW : SRW + 1;

  logic en;
  pim_pkg::pipe_ctl_t ctl_in, ctl1, ctl2, ctl3;

  logic                fr_vld;
  logic [R1W-1:0]      fr_nprod;
  logic signed [2*W:0] fr_dot;

  logic                r1_vld;
  logic [PW-1:0]       r1_root;
  logic [2*W:0]        r1_dot;

  logic signed [QW-1:0] diff;
  logic [XW-1:0]        qx;

  logic           q_vld_q;
  logic [SRW-1:0] q_rad_q;
  logic           q_sat_q;

  logic                          r2_vld;
  logic [pim_pkg::MASS_W-1:0]    r2_root;
  logic                          r2_sat;

  logic                          out_vld_q;
  logic [pim_pkg::MASS_W-1:0]    mass_q;
  logic                          mvalid_q;
  logic [pim_pkg::MASS_W-1:0]    mass_d;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign ctl_in = '{en: en, vld: s_axis_tvalid_i};

  pim_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .ax_i    (s_axis_tdata_i[0*W +: W]),
    .ay_i    (s_axis_tdata_i[1*W +: W]),
    .az_i    (s_axis_tdata_i[2*W +: W]),
    .bx_i    (s_axis_tdata_i[3*W +: W]),
    .by_i    (s_axis_tdata_i[4*W +: W]),
    .bz_i    (s_axis_tdata_i[5*W +: W]),
    .vld_o   (fr_vld),
    .nprod_o (fr_nprod),
    .dot_o   (fr_dot)
  );

  assign ctl1 = '{en: en, vld: fr_vld};

  pim_isqrt #(.RADW(R1W), .SW(2*W+1)) u_root_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1),
    .rad_i  (fr_nprod),
    .side_i (fr_dot),
    .vld_o  (r1_vld),
    .root_o (r1_root),
    .side_o (r1_dot)
  );

  // P >= |d|, so the difference is never negative
  assign diff = $signed({1'b0, r1_root}) - QW'($signed(r1_dot));
  assign qx   = XW'($unsigned(diff)) << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (en) begin
      q_vld_q <= r1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_rad_q <= qx[SRW-1:0];
      q_sat_q <= |qx[XW-1:SRW];
    end
  end

  assign ctl2 = '{en: en, vld: q_vld_q};

  pim_isqrt #(.RADW(SRW), .SW(1)) u_root_mass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl2),
    .rad_i  (q_rad_q),
    .side_i (q_sat_q),
    .vld_o  (r2_vld),
    .root_o (r2_root),
    .side_o (r2_sat)
  );

  assign ctl3   = '{en: en, vld: r2_vld};
  assign mass_d = r2_sat ? pim_pkg::MASS_MAX : r2_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl3.en) begin
      out_vld_q <= ctl3.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl3.en) begin
      mass_q   <= mass_d;
      mvalid_q <= |mass_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(32 - pim_pkg::MASS_W){1'b0}}, mass_q};
  assign m_axis_tuser_o  = mvalid_q;

`ifndef SYNTHESIS
  a_flag_matches_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o != 32'd0)))
    else $error("mass_valid disagrees with pair_mass");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(mass_q) && out_vld_q)
    else $error("stalled result changed");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for pair_invariant_mass_unit: table-driven and random pairs checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = 24;
  localparam int unsigned DW = ((6*W+7)/8)*8;
  localparam int unsigned LATENCY = 2*W+33;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 800;

  typedef struct packed {
    logic [W-1:0] sz, sy, sx, fz, fy, fx;
  } pair_t;

  typedef struct packed {
    logic [pim_pkg::MASS_W-1:0] mass;
    logic                       ok;
  } mass_t;

  // directed rows; known = 1 when the expected result is typed in
  typedef struct {
    pair_t p;
    bit    known;
    mass_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [DW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  pair_invariant_mass_unit #(.MOMENTUM_WIDTH(W)) u_top (.*);

  mass_t expected_masses[$];
  int errors = 0;
  bit stim_done = 0;
  bit rx_hold = 0;
  longint unsigned cycles = 0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic [127:0] isqrt128(logic [127:0] v);
    logic [127:0] r, b, t;
    r = '0;
    b = 128'd1 << 126;
    while (b != 0 && b > v) b = b >> 2;
    while (b != 0) begin
      t = r + b;
      if (v >= t) begin
        v = v - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic mass_t pair_mass(pair_t p);
    logic signed [W-1:0] a[3], b[3];
    logic signed [127:0] n1, n2, d;
    logic [127:0] acc, rt;
    mass_t m;
    a[0] = p.fx; a[1] = p.fy; a[2] = p.fz;
    b[0] = p.sx; b[1] = p.sy; b[2] = p.sz;
    n1 = 0; n2 = 0; d = 0;
    for (int i = 0; i < 3; i++) begin
      n1 += 128'(a[i]) * 128'(a[i]);
      n2 += 128'(b[i]) * 128'(b[i]);
      d  += 128'(a[i]) * 128'(b[i]);
    end
    acc = isqrt128(n1 * n2) - d;
    rt = isqrt128(acc << 1);
    m.mass = (rt > 128'(pim_pkg::MASS_MAX)) ? pim_pkg::MASS_MAX : rt[pim_pkg::MASS_W-1:0];
    m.ok = (m.mass != 0);
    return m;
  endfunction

  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return W'($urandom_range(0, 15)) - W'(8);
      3: return W'($urandom_range(0, 4095)) - W'(2048);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int k;
    p = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    k = $urandom_range(0, 9);
    if (k == 0) begin
      // parallel: second is first scaled
      p.sx = p.fx; p.sy = p.fy; p.sz = p.fz;
    end else if (k == 1) begin
      p.sx = -p.fx; p.sy = -p.fy; p.sz = -p.fz;
    end else if (k == 2) begin
      p.fx = '0; p.fy = '0; p.fz = '0;
    end
    return p;
  endfunction

  // valid stays high between items sent back to back
  task automatic send_item(pair_t p, int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DW'(p);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  function automatic int draw_gap(bit idle);
    return idle ? $urandom_range(0, 13) : 0;
  endfunction

  // stimulus
  initial begin
    row_t rows[$];
    row_t r;
    logic [W-1:0] mx, mn;
    pair_t p;
    bit idle;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    r.known = 1; r.res = '0;
    r.p = '0; rows.push_back(r);
    r.p = {W'(0), W'(0), W'(5), W'(0), W'(0), W'(5)}; rows.push_back(r);
    r.p = {mx, mx, mx, mx, mx, mx}; rows.push_back(r);
    r.p = {mn, mn, mn, mn, mn, mn}; rows.push_back(r);
    r.p = {W'(0), W'(0), W'(0), mx, mn, W'(1)}; rows.push_back(r);
    r.known = 0;
    r.p = {mn, mn, mn, mx, mx, mx}; rows.push_back(r);
    r.p = {mx, mx, mx, mn, mn, mn}; rows.push_back(r);
    r.p = {W'(0), W'(0), W'(-1), W'(0), W'(0), W'(1)}; rows.push_back(r);
    r.p = {W'(0), W'(1), W'(0), W'(0), W'(0), W'(1)}; rows.push_back(r);
    r.p = {mx, W'(0), W'(0), W'(0), W'(0), mx}; rows.push_back(r);
    r.p = {W'(0), W'(0), mn, W'(0), W'(0), mx}; rows.push_back(r);
    r.p = {W'(3), W'(-7), W'(100), W'(-50), W'(9), W'(2)}; rows.push_back(r);
    r.p = {W'(-1), W'(-1), W'(-1), W'(1), W'(1), W'(1)}; rows.push_back(r);
    r.p = {mn, W'(0), mx, W'(0), mx, mn}; rows.push_back(r);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      expected_masses.push_back(rows[i].known ? rows[i].res : pair_mass(rows[i].p));
      send_item(rows[i].p, draw_gap(1));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      idle = ((i / 100) % 2) == 0;
      if (i == 300) rx_hold = 1;
      if (i == 500) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        wait (expected_masses.size() == 0);
      end
      p = rand_pair();
      expected_masses.push_back(pair_mass(p));
      send_item(p, draw_gap(idle));
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1;
  end

  // receiver, with one long hold-off while the sender keeps going
  initial begin
    int stall;
    bit held = 0;
    forever begin
      if (rx_hold && !held) begin
        held = 1;
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = (cycles / 3000) % 2 == 0 ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    mass_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.mass = m_axis_tdata_o[pim_pkg::MASS_W-1:0];
      got.ok = m_axis_tuser_o;
      if (expected_masses.size() == 0) begin
        $display("%0t unexpected item: expected none, actual mass %0d valid %0b", $time,
                 got.mass, got.ok);
        errors = errors + 1;
      end else begin
        want = expected_masses.pop_front();
        if (got.mass != want.mass || m_axis_tdata_o[31:pim_pkg::MASS_W] != '0) begin
          $display("%0t mass mismatch: expected %0d actual %0d", $time, want.mass,
                   m_axis_tdata_o);
          errors = errors + 1;
        end
        if (got.ok != want.ok) begin
          $display("%0t valid mismatch: expected %0b actual %0b", $time, want.ok, got.ok);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_masses.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && expected_masses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("%0t timeout, %0d items outstanding", $time, expected_masses.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: files.f
design/pim_pkg.sv
design/pim_front.sv
design/pim_isqrt.sv
design/pair_invariant_mass_unit.sv
tb/testbench.sv
